/* hw/rtl/buddy_block_allocator_assert.svh */
// Assertion macros shared by the buddy allocator modules.
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// At most one of a group of signals is high at every rising edge outside reset.
`define BBA_ASSERT_ONEHOT0(lbl, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(sig)) \
		else $error(msg);

`endif

/* hw/rtl/bba_pkg.sv */
// Types and constants shared by the buddy allocator modules.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;
	localparam int MIN_BLOCK_BYTES = 16;
	localparam int NUM_LEVELS      = 8;
	localparam int LVL_W           = 3;
	localparam int UNIT_W          = NUM_LEVELS - 1;
	localparam int NUM_UNITS       = 1 << UNIT_W;
	localparam int SUB_W           = $clog2(MIN_BLOCK_BYTES);
	localparam int BYTES_W         = 13;
	localparam int OFF_W           = 11;
	localparam int IN_DATA_W       = 24;
	localparam int OUT_DATA_W      = 16;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_ZERO    = 2'd1,
		STAT_NOMEM   = 2'd2,
		STAT_INVALID = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SEARCH,
		S_SPLIT,
		S_TAGCHK,
		S_MERGE
	} state_t;

	typedef struct packed {
		logic    load;
		logic    search_step;
		logic    split_step;
		logic    tag_rd;
		logic    free_start;
		logic    merge_step;
		logic    emit;
		status_t emit_status;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic zero_req;
		logic too_big;
		logic bad_offset;
		logic tag_bad;
		logic hit;
		logic search_end;
		logic split_done;
		logic merge_go;
		logic out_free;
	} stat_t;
endpackage
`default_nettype wire

/* hw/rtl/bba_datapath.sv */
// Datapath of the buddy allocator: free map, block tags, working registers, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_block_allocator_assert.svh"
module bba_datapath
	import bba_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output stat_t                      stat,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tuser,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [LVL_W-1:0]      cfg_data,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata
);
	logic [NUM_UNITS-1:0] free_lvl_q [NUM_LEVELS];
	logic [LVL_W-1:0]     tag_mem_q [NUM_UNITS];
	logic [NUM_UNITS-1:0] tag_vld_q;
	logic [LVL_W-1:0]     tag_rdata_q;
	logic                 tag_rvld_q;

	logic [LVL_W-1:0]  pool_q;
	logic              mode_q;
	logic [LVL_W:0]    want_q;
	logic              zero_q;
	logic              sub_nz_q;
	logic [UNIT_W-1:0] unit_q;
	logic [LVL_W-1:0]  k_q;
	logic [UNIT_W-1:0] fidx_q;

	logic              out_vld_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [BYTES_W-1:0] req_bytes;
	logic [LVL_W:0]     want;
	logic [NUM_UNITS-1:0] cur_vec;
	logic               pe_any;
	logic [UNIT_W-1:0]  pe_idx;
	logic [LVL_W-1:0]   k_dn;
	logic [UNIT_W-1:0]  blk_unit;
	logic [UNIT_W-1:0]  buddy;

	assign req_bytes = s_tdata[BYTES_W-1:0];
	assign cfg_ready = 1'b1;

	// Smallest level whose block holds the request; NUM_LEVELS when none does.
	always_comb begin
		want = (LVL_W+1)'(NUM_LEVELS);
		for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
			if ((BYTES_W+1)'(req_bytes) <= (BYTES_W+1)'(MIN_BLOCK_BYTES << l)) begin
				want = (LVL_W+1)'(l);
			end
		end
	end

	// Lowest-address free block at the level under search.
	always_comb begin
		cur_vec = free_lvl_q[k_q];
		pe_any  = |cur_vec;
		pe_idx  = '0;
		for (int i = NUM_UNITS - 1; i >= 0; i--) begin
			if (cur_vec[i]) begin
				pe_idx = UNIT_W'(i);
			end
		end
	end

	assign k_dn     = k_q - LVL_W'(1);
	assign blk_unit = fidx_q << k_q;
	assign buddy    = fidx_q ^ UNIT_W'(1);

	always_comb begin
		stat.is_free    = mode_q;
		stat.zero_req   = zero_q;
		stat.too_big    = want_q > {1'b0, pool_q};
		stat.bad_offset = sub_nz_q || ((unit_q >> pool_q) != '0);
		stat.tag_bad    = !tag_rvld_q || (tag_rdata_q > pool_q);
		stat.hit        = pe_any;
		stat.search_end = k_q == pool_q;
		stat.split_done = k_q == want_q[LVL_W-1:0];
		stat.merge_go   = (k_q < pool_q) && free_lvl_q[k_q][buddy];
		stat.out_free   = !out_vld_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= LVL_W'(NUM_LEVELS - 1);
			for (int l = 0; l < NUM_LEVELS; l++) begin
				free_lvl_q[l] <= '0;
			end
			free_lvl_q[NUM_LEVELS-1][0] <= 1'b1;
			tag_vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				pool_q <= cfg_data;
				for (int l = 0; l < NUM_LEVELS; l++) begin
					free_lvl_q[l] <= '0;
				end
				free_lvl_q[cfg_data][0] <= 1'b1;
				tag_vld_q <= '0;
			end
			if (cmd.search_step && pe_any) begin
				free_lvl_q[k_q][pe_idx] <= 1'b0;
			end
			if (cmd.split_step) begin
				free_lvl_q[k_dn][{fidx_q[UNIT_W-2:0], 1'b1}] <= 1'b1;
			end
			if (cmd.free_start) begin
				tag_vld_q[unit_q] <= 1'b0;
			end
			if (cmd.merge_step) begin
				free_lvl_q[k_q][buddy] <= 1'b0;
			end
			if (cmd.emit && cmd.emit_status == STAT_OK) begin
				if (mode_q) begin
					free_lvl_q[k_q][fidx_q] <= 1'b1;
				end else begin
					tag_vld_q[blk_unit] <= 1'b1;
				end
			end
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Tag memory and working registers carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.emit && cmd.emit_status == STAT_OK && !mode_q) begin
			tag_mem_q[blk_unit] <= k_q;
		end
		if (cmd.tag_rd) begin
			tag_rdata_q <= tag_mem_q[unit_q];
			tag_rvld_q  <= tag_vld_q[unit_q];
		end
		if (cmd.load) begin
			mode_q   <= s_tuser;
			want_q   <= want;
			zero_q   <= req_bytes == '0;
			sub_nz_q <= s_tdata[BYTES_W +: SUB_W] != '0;
			unit_q   <= s_tdata[BYTES_W+SUB_W +: UNIT_W];
			k_q      <= want[LVL_W-1:0];
		end
		if (cmd.search_step) begin
			if (pe_any) begin
				fidx_q <= pe_idx;
			end else begin
				k_q <= k_q + LVL_W'(1);
			end
		end
		if (cmd.split_step) begin
			k_q    <= k_dn;
			fidx_q <= {fidx_q[UNIT_W-2:0], 1'b0};
		end
		if (cmd.free_start) begin
			k_q    <= tag_rdata_q;
			fidx_q <= unit_q >> tag_rdata_q;
		end
		if (cmd.merge_step) begin
			k_q    <= k_q + LVL_W'(1);
			fidx_q <= fidx_q >> 1;
		end
		if (cmd.emit) begin
			if (cmd.emit_status == STAT_OK) begin
				out_data_q <= {k_q, blk_unit, {SUB_W{1'b0}}, cmd.emit_status};
			end else begin
				out_data_q <= {{(OUT_DATA_W-2){1'b0}}, cmd.emit_status};
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	`BBA_ASSERT_IMP(a_emit_no_overwrite, cmd.emit, !out_vld_q || m_tready, "result overwritten")
	`BBA_ASSERT_IMP(a_split_above_target, cmd.split_step, k_q > want_q[LVL_W-1:0], "split below target")
	`BBA_ASSERT_IMP(a_merge_below_pool, cmd.merge_step, k_q < pool_q, "merge beyond pool")
endmodule
`default_nettype wire

/* hw/rtl/bba_controller.sv */
// Controller state machine of the buddy allocator.
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_block_allocator_assert.svh"
module bba_controller
	import bba_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output logic       s_tready,
	input  wire stat_t stat,
	output cmd_t       cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.is_free) begin
					if (!stat.bad_offset) state_d = S_TAGCHK;
					else if (stat.out_free) state_d = S_IDLE;
				end else if (!stat.zero_req && !stat.too_big) begin
					state_d = S_SEARCH;
				end else if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_TAGCHK: begin
				if (!stat.tag_bad) state_d = S_MERGE;
				else if (stat.out_free) state_d = S_IDLE;
			end
			S_SEARCH: begin
				if (stat.hit) state_d = S_SPLIT;
				else if (stat.search_end && stat.out_free) state_d = S_IDLE;
			end
			S_SPLIT: begin
				if (stat.split_done && stat.out_free) state_d = S_IDLE;
			end
			S_MERGE: begin
				if (!stat.merge_go && stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.emit_status = STAT_OK;
		s_tready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_CHECK: begin
				if (stat.is_free) begin
					cmd.tag_rd      = !stat.bad_offset;
					cmd.emit        = stat.bad_offset && stat.out_free;
					cmd.emit_status = STAT_INVALID;
				end else if (stat.zero_req) begin
					cmd.emit        = stat.out_free;
					cmd.emit_status = STAT_ZERO;
				end else if (stat.too_big) begin
					cmd.emit        = stat.out_free;
					cmd.emit_status = STAT_NOMEM;
				end
			end
			S_TAGCHK: begin
				cmd.free_start  = !stat.tag_bad;
				cmd.emit        = stat.tag_bad && stat.out_free;
				cmd.emit_status = STAT_INVALID;
			end
			S_SEARCH: begin
				if (stat.hit || !stat.search_end) begin
					cmd.search_step = 1'b1;
				end else begin
					cmd.emit        = stat.out_free;
					cmd.emit_status = STAT_NOMEM;
				end
			end
			S_SPLIT: begin
				cmd.split_step = !stat.split_done;
				cmd.emit       = stat.split_done && stat.out_free;
			end
			S_MERGE: begin
				cmd.merge_step = stat.merge_go;
				cmd.emit       = !stat.merge_go && stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`BBA_ASSERT_ONEHOT0(a_one_cmd, {cmd.load, cmd.search_step, cmd.split_step, cmd.tag_rd, cmd.free_start, cmd.merge_step, cmd.emit}, "commands overlap")
	`BBA_ASSERT_IMP(a_emit_space, cmd.emit, stat.out_free, "emit without room")
	`BBA_ASSERT_IMP(a_load_idle, cmd.load, state_q == S_IDLE, "load outside idle")
endmodule
`default_nettype wire

/* hw/rtl/buddy_block_allocator.sv */
// Top level of the binary buddy block allocator.
// Channel | Direction | Handshake        | Payload
// s_      | in        | s_tvalid/tready  | tuser: mode; tdata: request_bytes, block_offset
// m_      | out       | m_tvalid/tready  | tdata: status, granted_offset, granted_level
// cfg_    | in        | cfg_valid/ready  | cfg_data: pool_level
// An allocate checks the request, searches the free map upward, then splits down to the wanted level.
// A free checks the offset and the block tag, then merges with free buddies level by level.
// One item is worked on at a time; the result register frees the engine while a result waits.
// A stalled result holds the engine only at the cycle that would write the next result.
// Reset and every pool_level write leave only the pool root free and clear all block tags.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator
	import bba_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // request_bytes[12:0], block_offset[23:13]
	input  wire logic                  s_tuser,  // mode
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // status[1:0], granted_offset[12:2], granted_level[15:13]
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [LVL_W-1:0]      cfg_data
);
	cmd_t  cmd;
	stat_t stat;

	bba_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bba_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);
endmodule
`default_nettype wire
